[design/lcv_pkg.sv]
package lcv_pkg;

    // defaults for the top level parameters
    localparam int MAX_ITEMS_DEF   = 1024;
    localparam int VALUE_WIDTH_DEF = 16;

    // fixed field widths on the stream ports
    localparam int IN_FIELD_W  = 16;
    localparam int CHAIN_OUT_W = 11;
    localparam int S_TDATA_W   = 3 * IN_FIELD_W;
    localparam int M_TDATA_W   = 16;

    // largest chain length that fits the result field
    localparam logic [CHAIN_OUT_W-1:0] CHAIN_SAT = {CHAIN_OUT_W{1'b1}};

endpackage

[design/lcv_ram.sv]
module lcv_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/longest_chain_with_variants.sv]
// longest chain with variants
// input stream (s_axis): one transaction per element; tdata holds base, lowest and
// highest value, tlast marks the final element of a sequence. the element gets a
// chain length of 1 plus the best chain length of any earlier element whose
// highest value is at most its base and whose base is at most its lowest value.
// output stream (m_axis): one transaction per sequence, after the element with
// tlast, carrying the longest chain length (saturated to 11 bits) and a flag set
// when more than MAX_ITEMS elements arrived; extra elements are dropped.
// steps: an element that finds elements already stored is checked against them by a
// scan through the element memory at one read per cycle, then stored in a write-back
// step; the first element of a sequence goes straight to the write-back step and a
// dropped element needs no further step; a final element then loads the output register.
// the output register lets the next sequence start while a result waits; if the
// receiver still holds the previous result when a new one is ready, the block
// waits and accepts no element until the output register frees up.
// reset clears the element count, running best, overflow flag and output valid;
// the memory needs no clearing because only entries of the current sequence are read.
module longest_chain_with_variants #(
    parameter int MAX_ITEMS   = lcv_pkg::MAX_ITEMS_DEF,
    parameter int VALUE_WIDTH = lcv_pkg::VALUE_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // base_value [15:0], lowest_value [31:16], highest_value [47:32]
    input  logic [lcv_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // last_item
    input  logic                         s_axis_tlast,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // chain_length [10:0], overflowed [11], zero [15:12]
    output logic [lcv_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    import lcv_pkg::*;

    localparam int SW   = (VALUE_WIDTH < IN_FIELD_W) ? VALUE_WIDTH : IN_FIELD_W;
    localparam int CW   = $clog2(MAX_ITEMS + 1);
    localparam int AW   = $clog2(MAX_ITEMS);
    localparam int MW   = CW + 2 * SW;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_EMIT
    } state_t;

    state_t                 state_reg;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          best_reg;
    logic                   ovf_reg;
    logic [CW-1:0]          issue_reg;
    logic                   pending_reg;
    logic [CW-1:0]          prev_reg;
    logic [SW-1:0]          base_reg;
    logic [SW-1:0]          low_reg;
    logic [SW-1:0]          high_reg;
    logic                   last_reg;
    logic                   out_valid_reg;
    logic [CHAIN_OUT_W-1:0] out_chain_reg;
    logic                   out_ovf_reg;

    logic                   rd_en;
    logic [MW-1:0]          rd_data;
    logic [SW-1:0]          rd_base;
    logic [SW-1:0]          rd_high;
    logic [CW-1:0]          rd_chain;
    logic                   hit;
    logic                   wr_en;
    logic [CW-1:0]          chain_new;
    logic [CHAIN_OUT_W-1:0] chain_sat;
    logic                   out_free;

    // memory entry layout: {chain, high, base}
    assign rd_base  = rd_data[SW-1:0];
    assign rd_high  = rd_data[2*SW-1:SW];
    assign rd_chain = rd_data[MW-1:2*SW];

    assign rd_en     = (state_reg == ST_SCAN) && (issue_reg < count_reg);
    assign wr_en     = (state_reg == ST_WRITE);
    assign chain_new = prev_reg + CW'(1);
    assign hit       = pending_reg && (rd_high <= base_reg) && (rd_base <= low_reg)
                       && (rd_chain > prev_reg);

    assign chain_sat = (32'(best_reg) > 32'(CHAIN_SAT)) ? CHAIN_SAT
                                                         : CHAIN_OUT_W'(best_reg);
    assign out_free  = !out_valid_reg || m_axis_tready;

    lcv_ram #(
        .WIDTH (MW),
        .DEPTH (MAX_ITEMS),
        .ADDR_W(AW)
    ) u_store (
        .clk  (clk),
        .we   (wr_en),
        .waddr(count_reg[AW-1:0]),
        .wdata({chain_new, high_reg, base_reg}),
        .re   (rd_en),
        .raddr(issue_reg[AW-1:0]),
        .rdata(rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            best_reg      <= '0;
            ovf_reg       <= 1'b0;
            issue_reg     <= '0;
            pending_reg   <= 1'b0;
            prev_reg      <= '0;
            base_reg      <= '0;
            low_reg       <= '0;
            high_reg      <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_chain_reg <= '0;
            out_ovf_reg   <= 1'b0;
        end
        else
        begin
            // in the emit step the output register is reloaded instead
            if (m_axis_tvalid && m_axis_tready && (state_reg != ST_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        base_reg    <= SW'(s_axis_tdata[IN_FIELD_W-1:0]);
                        low_reg     <= SW'(s_axis_tdata[2*IN_FIELD_W-1:IN_FIELD_W]);
                        high_reg    <= SW'(s_axis_tdata[3*IN_FIELD_W-1:2*IN_FIELD_W]);
                        last_reg    <= s_axis_tlast;
                        issue_reg   <= '0;
                        pending_reg <= 1'b0;
                        prev_reg    <= '0;
                        if (count_reg < MAX_CNT)
                        begin
                            state_reg <= (count_reg == '0) ? ST_WRITE : ST_SCAN;
                        end
                        else
                        begin
                            // sequence full: element dropped
                            ovf_reg   <= 1'b1;
                            state_reg <= s_axis_tlast ? ST_EMIT : ST_IDLE;
                        end
                    end
                end

                ST_SCAN:
                begin
                    if (hit)
                    begin
                        prev_reg <= rd_chain;
                    end
                    if (issue_reg < count_reg)
                    begin
                        issue_reg   <= issue_reg + CW'(1);
                        pending_reg <= 1'b1;
                    end
                    else
                    begin
                        // last read data consumed this cycle
                        pending_reg <= 1'b0;
                        state_reg   <= ST_WRITE;
                    end
                end

                ST_WRITE:
                begin
                    count_reg <= count_reg + CW'(1);
                    if (chain_new > best_reg)
                    begin
                        best_reg <= chain_new;
                    end
                    state_reg <= last_reg ? ST_EMIT : ST_IDLE;
                end

                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_chain_reg <= chain_sat;
                        out_ovf_reg   <= ovf_reg;
                        count_reg     <= '0;
                        best_reg      <= '0;
                        ovf_reg       <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'({out_ovf_reg, out_chain_reg});

`ifndef NO_ASSERTIONS
    // a chain can never be longer than the number of stored elements
    a_best_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        32'(best_reg) <= 32'(count_reg))
        else $error("running best exceeds element count");

    // a write never lands beyond the configured capacity
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (count_reg < MAX_CNT))
        else $error("memory write with full sequence");

    // the scan reads only entries of the current sequence
    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (issue_reg < count_reg) && (32'(issue_reg) < MAX_ITEMS))
        else $error("scan read beyond stored elements");

    // during the scan the best predecessor is bounded by the entries read
    a_prev_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (prev_reg <= issue_reg))
        else $error("predecessor chain length out of range");

    // a new result only appears after the emit step
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result raised outside emit step");

    // after a result is loaded the sequence state starts empty
    a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EMIT) && out_free) |=> (count_reg == '0) && !ovf_reg
        && (best_reg == '0))
        else $error("sequence state not cleared after result");
`endif

endmodule

[verif/tb_longest_chain_with_variants.sv]
module tb_longest_chain_with_variants;
    timeunit 1ns;
    timeprecision 1ps;

    import lcv_pkg::*;

    localparam int MAX_ITEMS    = MAX_ITEMS_DEF;
    localparam int VALUE_WIDTH  = VALUE_WIDTH_DEF;
    localparam int RAND_ITEMS   = 580;
    localparam int SQUEEZE_LEN  = 3000;
    localparam int IDLE_LIMIT   = 20000;
    localparam int SETTLE_WAIT  = 40;

    class chain_scoreboard;
        bit [VALUE_WIDTH-1:0] base_mem [MAX_ITEMS];
        bit [VALUE_WIDTH-1:0] high_mem [MAX_ITEMS];
        int unsigned          chain_mem [MAX_ITEMS];
        int unsigned          stored;
        int unsigned          best;
        bit                   dropped;
        logic [M_TDATA_W-1:0] expected_q [$];
        int                   errors;

        function new();
            stored  = 0;
            best    = 0;
            dropped = 1'b0;
            errors  = 0;
        endfunction

        // runs the chain scan for one accepted element
        function void note_element(bit [IN_FIELD_W-1:0] b, bit [IN_FIELD_W-1:0] l,
                                   bit [IN_FIELD_W-1:0] h, bit last);
            bit [VALUE_WIDTH-1:0]   bv;
            bit [VALUE_WIDTH-1:0]   lv;
            bit [VALUE_WIDTH-1:0]   hv;
            int unsigned            prev;
            bit [CHAIN_OUT_W-1:0]   chain_out;
            bv = b[VALUE_WIDTH-1:0];
            lv = l[VALUE_WIDTH-1:0];
            hv = h[VALUE_WIDTH-1:0];
            if (stored < MAX_ITEMS) begin
                prev = 0;
                for (int j = 0; j < stored; j++) begin
                    if (high_mem[j] <= bv && base_mem[j] <= lv && chain_mem[j] > prev)
                        prev = chain_mem[j];
                end
                base_mem[stored]  = bv;
                high_mem[stored]  = hv;
                chain_mem[stored] = prev + 1;
                if (prev + 1 > best)
                    best = prev + 1;
                stored++;
            end
            else begin
                dropped = 1'b1;
            end
            if (last) begin
                chain_out = (best > CHAIN_SAT) ? CHAIN_SAT : best[CHAIN_OUT_W-1:0];
                expected_q.push_back({{(M_TDATA_W-CHAIN_OUT_W-1){1'b0}}, dropped, chain_out});
                stored  = 0;
                best    = 0;
                dropped = 1'b0;
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] got);
            logic [M_TDATA_W-1:0] want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected result transaction, data %h", $realtime, got);
                return;
            end
            want = expected_q.pop_front();
            if (got[CHAIN_OUT_W-1:0] !== want[CHAIN_OUT_W-1:0]
                || got[CHAIN_OUT_W] !== want[CHAIN_OUT_W]
                || got[M_TDATA_W-1:CHAIN_OUT_W+1] !== want[M_TDATA_W-1:CHAIN_OUT_W+1]) begin
                errors++;
                if (errors <= 10) begin
                    $display("%0t: mismatch chain_length exp %0d got %0d, overflowed exp %b got %b",
                             $realtime, want[CHAIN_OUT_W-1:0], got[CHAIN_OUT_W-1:0],
                             want[CHAIN_OUT_W], got[CHAIN_OUT_W]);
                    $display("    pad exp %h got %h",
                             want[M_TDATA_W-1:CHAIN_OUT_W+1], got[M_TDATA_W-1:CHAIN_OUT_W+1]);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;

    chain_scoreboard sb = new();

    int  burst_left = 0;
    int  idle_cycles = 0;
    bit  squeeze_go = 1'b0;
    bit  squeeze_seen = 1'b0;
    int  hold_left = 0;
    int  rx_mode = 0;
    int  rx_mode_left = 0;

    longest_chain_with_variants #(
        .MAX_ITEMS   (MAX_ITEMS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // result side: check accepted transactions, then pick the next tready
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if (squeeze_go && !squeeze_seen) begin
                squeeze_seen = 1'b1;
                hold_left = SQUEEZE_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else begin
                if (rx_mode_left == 0) begin
                    rx_mode = $urandom_range(0, 3);
                    rx_mode_left = $urandom_range(32, 400);
                end
                rx_mode_left--;
                case (rx_mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= ((rx_mode_left % 16) < 4);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_longest_chain_with_variants failed");
                $finish;
            end
        end
    end

    // bursts of random length with random gaps, sometimes no gap at all
    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
    endtask

    task automatic send_element(input bit [IN_FIELD_W-1:0] b, input bit [IN_FIELD_W-1:0] l,
                                input bit [IN_FIELD_W-1:0] h, input bit last);
        pace();
        s_axis_tdata  <= {h, l, b};
        s_axis_tlast  <= last;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_element(b, l, h, last);
    endtask

    task automatic make_element(output bit [IN_FIELD_W-1:0] b, output bit [IN_FIELD_W-1:0] l,
                                output bit [IN_FIELD_W-1:0] h);
        int pick;
        int bi;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            // narrow values so chains actually form
            bi = $urandom_range(0, 60);
            b  = IN_FIELD_W'(bi);
            l  = IN_FIELD_W'(bi - $urandom_range(0, (bi < 8) ? bi : 8));
            h  = IN_FIELD_W'(bi + $urandom_range(0, 8));
        end
        else if (pick < 85) begin
            b = IN_FIELD_W'($urandom());
            l = IN_FIELD_W'($urandom());
            h = IN_FIELD_W'($urandom());
        end
        else begin
            bi = $urandom_range(0, 65535);
            b  = IN_FIELD_W'(bi);
            l  = IN_FIELD_W'($urandom_range(0, bi));
            h  = IN_FIELD_W'($urandom_range(bi, 65535));
        end
    endtask

    task automatic send_random_seq(input int len);
        bit [IN_FIELD_W-1:0] b;
        bit [IN_FIELD_W-1:0] l;
        bit [IN_FIELD_W-1:0] h;
        for (int i = 0; i < len; i++) begin
            make_element(b, l, h);
            send_element(b, l, h, i == len - 1);
        end
    endtask

    initial
    begin
        int                  sent;
        int                  len;
        bit [IN_FIELD_W-1:0] b;
        bit [IN_FIELD_W-1:0] l;
        bit [IN_FIELD_W-1:0] h;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single elements at both extremes
        send_element(16'h0000, 16'h0000, 16'h0000, 1'b1);
        send_element(16'hffff, 16'hffff, 16'hffff, 1'b1);
        // equal values chain, then the top value extends it
        send_element(16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_element(16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_element(16'hffff, 16'hffff, 16'hffff, 1'b1);
        // highest above the next base blocks, equal to it allows
        send_element(16'd5, 16'd5, 16'd10, 1'b0);
        send_element(16'd9, 16'd9, 16'd9, 1'b0);
        send_element(16'd10, 16'd10, 16'd10, 1'b1);
        // inconsistent ranges used as given
        send_element(16'd100, 16'd200, 16'd50, 1'b0);
        send_element(16'd60, 16'd60, 16'd60, 1'b0);
        send_element(16'd100, 16'd100, 16'd100, 1'b0);
        send_element(16'd100, 16'd99, 16'd100, 1'b1);
        // strictly decreasing gives one
        send_element(16'd40, 16'd40, 16'd40, 1'b0);
        send_element(16'd30, 16'd30, 16'd30, 1'b0);
        send_element(16'd20, 16'd20, 16'd20, 1'b0);
        send_element(16'd10, 16'd10, 16'd10, 1'b1);
        // alternating bit patterns
        send_element(16'h5555, 16'haaaa, 16'h5555, 1'b0);
        send_element(16'haaaa, 16'h5555, 16'haaaa, 1'b0);
        send_element(16'haaaa, 16'haaaa, 16'hffff, 1'b1);

        // full memory with a rising chain, then dropped elements, last one dropped too
        for (int i = 0; i < MAX_ITEMS + 3; i++) begin
            if (i < MAX_ITEMS) begin
                b = IN_FIELD_W'(i);
                l = IN_FIELD_W'(i);
                h = IN_FIELD_W'(i);
            end
            else begin
                make_element(b, l, h);
            end
            send_element(b, l, h, i == MAX_ITEMS + 2);
        end

        sent = 0;
        while (sent < RAND_ITEMS) begin
            if (!squeeze_go && sent > 200) begin
                // receiver holds off while short sequences keep coming
                squeeze_go = 1'b1;
                for (int k = 0; k < 30; k++) begin
                    len = $urandom_range(1, 2);
                    send_random_seq(len);
                    sent += len;
                end
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 24);
            send_random_seq(len);
            sent += len;
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_longest_chain_with_variants passed");
        else
            $display("tb_longest_chain_with_variants failed");
        $finish;
    end

endmodule

[filelist.f]
design/lcv_pkg.sv
design/lcv_ram.sv
design/longest_chain_with_variants.sv
verif/tb_longest_chain_with_variants.sv
